// ===== sv/vrs_pkg.sv =====
// Shared types, constants and state encoding for the voxel ray stepper.
package vrs_pkg;

   localparam int MAG_W       = 16;
   localparam int TIME_W      = 32;
   localparam int CNT_W       = 7;
   localparam int DIV_ITER    = 16;
   localparam int DIV_CNT_W   = $clog2(DIV_ITER);
   localparam logic [CNT_W-1:0] MAX_STEPS     = 7'd64;
   localparam logic [7:0]       FLOOR_Y_RESET = 8'd6;
   localparam logic [TIME_W-1:0] TIME_SAT     = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] start_z;
      logic [CNT_W-1:0]   step_count;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic signed [15:0] cell_z;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
      logic signed [15:0] end_z;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [MAG_W-1:0]   divisor;
   } div_cmd_type;

endpackage

// ===== sv/vrs_div.sv =====
// Iterative restoring divider: 2^31 / divisor, two quotient bits per cycle.
module vrs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  vrs_pkg::div_cmd_type       cmd,
   output logic                       done,
   output logic [vrs_pkg::TIME_W-1:0] quotient
);
   import vrs_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [MAG_W-1:0]     rem_ff;
   logic [MAG_W-1:0]     dvs_ff;
   logic [TIME_W-1:0]    quo_ff;
   logic [MAG_W:0]       s1;
   logic [MAG_W:0]       s2;
   logic                 first_bit;

   // One restoring step: returns {quotient bit, new remainder}.
   function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
                                               input logic             nb,
                                               input logic [MAG_W-1:0] d);
      logic [MAG_W:0] r;
      logic [MAG_W:0] diff;
      begin
         r    = {rem, nb};
         diff = r - {1'b0, d};
         if (r >= {1'b0, d}) begin
            div_step = {1'b1, diff[MAG_W-1:0]};
         end else begin
            div_step = {1'b0, r[MAG_W-1:0]};
         end
      end
   endfunction

   // The dividend has only its top bit set.
   assign first_bit = (cnt_ff == '0);
   assign s1        = div_step(rem_ff, first_bit, dvs_ff);
   assign s2        = div_step(s1[MAG_W-1:0], 1'b0, dvs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_ITER - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= '0;
         quo_ff <= '0;
         dvs_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff <= s2[MAG_W-1:0];
         quo_ff <= {quo_ff[TIME_W-3:0], s1[MAG_W], s2[MAG_W]};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/voxel_ray_stepper_top.sv =====
// Voxel ray stepper: per-ray setup on a shared divider, then one cell per cycle.
// Setup: after a ray is accepted, the shared divider forms a reciprocal for each axis in turn,
// X, Y then Z (start, divide and done per axis); the walk then begins.
// Then one result per cycle while rsp_ready stays high; a held result stalls the walk.
// A new ray is accepted only while idle, after the last result of the previous ray is issued;
// the one divider serves all three axes. Reset (synchronous) clears control state, floor_y to 6.
module voxel_ray_stepper_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vrs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   import vrs_pkg::*;

   state_type         state_ff, state_in;
   axis_type          axis_ff;
   logic [7:0]        floor_y_ff;
   logic signed [15:0] dir_ff  [3];
   logic signed [15:0] cell_ff [3];
   logic [TIME_W-1:0] tmax_ff [3];
   logic [TIME_W-1:0] tdel_ff [3];
   logic [2:0]        never_ff;
   logic [CNT_W-1:0]  left_ff;
   logic              start_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              req_fire;
   logic              advance;
   logic              div_done;
   logic [TIME_W-1:0] div_q;
   div_cmd_type       div_cmd;
   logic [MAG_W-1:0]  mag_sel;
   logic signed [15:0] dir_sel;
   logic [CNT_W-1:0]  count_in;
   logic              x_lt_y, x_lt_z, y_lt_z;
   logic              sel_x, sel_y, sel_z;
   logic [1:0]        sel_axis;
   logic [TIME_W:0]   tsum;
   logic [TIME_W-1:0] tnext;
   logic signed [15:0] next_x, next_y, next_z, y_step;
   logic              is_last;

   // Axis a fires before axis b: a is reachable, and b is not or a is strictly earlier.
   function automatic logic earlier(input logic na, input logic nb,
                                    input logic [TIME_W-1:0] ta,
                                    input logic [TIME_W-1:0] tb);
      begin
         earlier = !na && (nb || (ta < tb));
      end
   endfunction

   function automatic logic signed [15:0] step_cell(input logic signed [15:0] c,
                                                   input logic signed [15:0] d);
      begin
         step_cell = d[15] ? c - 16'sd1 : c + 16'sd1;
      end
   endfunction

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.step_count != '0)) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done && (axis_ff == AXIS_Z)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (advance && (left_ff == CNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- outputs of the sequencer ----
   always_comb begin
      req_ready = 1'b0;
      advance   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DIV:  req_ready = 1'b0;
         ST_WALK: advance   = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign count_in  = (req_data.step_count > MAX_STEPS) ? MAX_STEPS : req_data.step_count;

   // ---- divider ----
   assign dir_sel         = dir_ff[axis_ff];
   assign mag_sel         = dir_sel[15] ? MAG_W'(-dir_sel) : MAG_W'(dir_sel);
   assign div_cmd.start   = start_ff;
   assign div_cmd.divisor = mag_sel;

   vrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---- axis choice and shared time adder ----
   assign x_lt_y = earlier(never_ff[0], never_ff[1], tmax_ff[0], tmax_ff[1]);
   assign x_lt_z = earlier(never_ff[0], never_ff[2], tmax_ff[0], tmax_ff[2]);
   assign y_lt_z = earlier(never_ff[1], never_ff[2], tmax_ff[1], tmax_ff[2]);
   assign sel_x  = x_lt_y && x_lt_z;
   assign sel_y  = !sel_x && y_lt_z;
   assign sel_z  = !sel_x && !sel_y && !never_ff[2];

   always_comb begin
      if (sel_x) begin
         sel_axis = AXIS_X;
      end else if (sel_y) begin
         sel_axis = AXIS_Y;
      end else begin
         sel_axis = AXIS_Z;
      end
   end

   assign tsum  = {1'b0, tmax_ff[sel_axis]} + {1'b0, tdel_ff[sel_axis]};
   assign tnext = tsum[TIME_W] ? TIME_SAT : tsum[TIME_W-1:0];

   assign y_step = step_cell(cell_ff[1], dir_ff[1]);
   assign next_x = sel_x ? step_cell(cell_ff[0], dir_ff[0]) : cell_ff[0];
   assign next_z = sel_z ? step_cell(cell_ff[2], dir_ff[2]) : cell_ff[2];
   always_comb begin
      next_y = cell_ff[1];
      if (sel_y) begin
         // Clamp the stepped y up to the floor.
         next_y = (y_step < $signed({8'd0, floor_y_ff})) ? $signed({8'd0, floor_y_ff})
                                                         : y_step;
      end
   end

   assign is_last = (left_ff == CNT_W'(1));

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         floor_y_ff   <= FLOOR_Y_RESET;
         left_ff      <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            floor_y_ff <= csr_data;
         end
         if (req_fire) begin
            axis_ff  <= AXIS_X;
            left_ff  <= count_in;
            start_ff <= (count_in != '0);
         end
         if ((state_ff == ST_DIV) && div_done && (axis_ff != AXIS_Z)) begin
            axis_ff  <= axis_type'(axis_ff + 2'd1);
            start_ff <= 1'b1;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            left_ff      <= left_ff - 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dir_ff[0]  <= req_data.dir_x;
         dir_ff[1]  <= req_data.dir_y;
         dir_ff[2]  <= req_data.dir_z;
         cell_ff[0] <= req_data.start_x;
         cell_ff[1] <= req_data.start_y;
         cell_ff[2] <= req_data.start_z;
      end
      if ((state_ff == ST_DIV) && div_done) begin
         tdel_ff[axis_ff]  <= div_q;
         tmax_ff[axis_ff]  <= dir_sel[15] ? '0 : div_q;
         never_ff[axis_ff] <= (dir_sel == 16'sd0);
      end
      if (advance) begin
         rsp_ff.cell_x <= cell_ff[0];
         rsp_ff.cell_y <= cell_ff[1];
         rsp_ff.cell_z <= cell_ff[2];
         rsp_ff.end_x  <= is_last ? next_x : 16'sd0;
         rsp_ff.end_y  <= is_last ? next_y : 16'sd0;
         rsp_ff.end_z  <= is_last ? next_z : 16'sd0;
         rsp_ff.last   <= is_last;
         cell_ff[0]    <= next_x;
         cell_ff[1]    <= next_y;
         cell_ff[2]    <= next_z;
         if (sel_x || sel_y || sel_z) begin
            tmax_ff[sel_axis] <= tnext;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== dv/voxel_ray_stepper_top_test.sv =====
// Self-checking testbench for the voxel ray stepper: directed rays, then random rays.
`timescale 1ns / 1ps

module voxel_ray_stepper_top_test;
   import vrs_pkg::*;

   localparam int    SETTLE     = 120;
   localparam int    LONG_HOLD  = 400;
   localparam longint T_SAT     = longint'(TIME_SAT);
   localparam longint T_NEVER   = longint'(TIME_SAT) + 1;

   typedef struct {
      req_type ray;
      bit      typed;
      rsp_type want;
   } ray_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [7:0] csr_data;

   rsp_type     cells_due[$];
   ray_row_type directed_rays[$];
   logic [7:0] floor_model = FLOOR_Y_RESET;
   int         mismatch_count = 0;
   int         rays_sent = 0;
   int         cells_checked = 0;
   int         floors_written = 0;
   bit         stall_request = 0;
   bit         steady = 0;

   voxel_ray_stepper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d cells still due", cells_due.size());
      $display("voxel_ray_stepper_top: mismatch");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   function automatic req_type mk_ray(input int dx, input int dy, input int dz,
                                      input int sx, input int sy, input int sz,
                                      input int n);
      req_type r;
      r.dir_x      = 16'(dx);
      r.dir_y      = 16'(dy);
      r.dir_z      = 16'(dz);
      r.start_x    = 16'(sx);
      r.start_y    = 16'(sy);
      r.start_z    = 16'(sz);
      r.step_count = 7'(n);
      return r;
   endfunction

   function automatic rsp_type mk_cell(input int cx, input int cy, input int cz,
                                       input int ex, input int ey, input int ez);
      rsp_type c;
      c.cell_x = 16'(cx);
      c.cell_y = 16'(cy);
      c.cell_z = 16'(cz);
      c.end_x  = 16'(ex);
      c.end_y  = 16'(ey);
      c.end_z  = 16'(ez);
      c.last   = 1'b1;
      return c;
   endfunction

   // Queue every cell the ray visits, under the current floor.
   function automatic void walk_ray(input req_type ray);
      logic signed [15:0] dir [0:2];
      logic [15:0]        pos [0:2];
      longint             t_next [0:2];
      longint             t_inc [0:2];
      int                 stepv [0:2];
      int                 d;
      int                 mag;
      int                 count;
      int                 a;
      bit                 moves;
      axis_type           pick;
      rsp_type            res;
      dir[0] = ray.dir_x;
      dir[1] = ray.dir_y;
      dir[2] = ray.dir_z;
      pos[0] = ray.start_x;
      pos[1] = ray.start_y;
      pos[2] = ray.start_z;
      for (a = 0; a < 3; a++) begin
         d = int'(dir[a]);
         if (d == 0) begin
            stepv[a]  = 0;
            t_inc[a]  = 0;
            t_next[a] = T_NEVER;
         end else begin
            mag       = (d < 0) ? -d : d;
            stepv[a]  = (d > 0) ? 1 : -1;
            t_inc[a]  = (longint'(1) << 31) / longint'(mag);
            t_next[a] = (d > 0) ? t_inc[a] : 0;
         end
      end
      count = (ray.step_count > MAX_STEPS) ? int'(MAX_STEPS) : int'(ray.step_count);
      for (int k = 0; k < count; k++) begin
         res.cell_x = pos[0];
         res.cell_y = pos[1];
         res.cell_z = pos[2];
         moves = 1'b1;
         pick  = AXIS_Z;
         if (t_next[0] < t_next[1] && t_next[0] < t_next[2])
            pick = AXIS_X;
         else if (t_next[1] < t_next[2])
            pick = AXIS_Y;
         else if (t_next[2] == T_NEVER)
            moves = 1'b0;
         if (moves) begin
            a = int'(pick);
            pos[a] = pos[a] + 16'(stepv[a]);
            // clamp on the wrapped y, read as signed
            if (pick == AXIS_Y && int'($signed(pos[1])) < int'(floor_model))
               pos[1] = 16'(floor_model);
            t_next[a] = (t_next[a] + t_inc[a] > T_SAT) ? T_SAT : t_next[a] + t_inc[a];
         end
         if (k + 1 == count) begin
            res.end_x = pos[0];
            res.end_y = pos[1];
            res.end_z = pos[2];
            res.last  = 1'b1;
         end else begin
            res.end_x = '0;
            res.end_y = '0;
            res.end_z = '0;
            res.last  = 1'b0;
         end
         cells_due.push_back(res);
      end
   endfunction

   task automatic send_ray(input req_type ray, input bit typed, input rsp_type want,
                           input bit no_gaps);
      req_data  <= ray;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      rays_sent++;
      if (!typed)
         walk_ray(ray);
      else if (ray.step_count != 0)
         cells_due.push_back(want);
      // hold valid high for the next item unless a gap is drawn
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] rand_dir();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'h0000;
         1: v = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         2: begin
            v = 16'($urandom_range(1, 8));
            if ($urandom_range(0, 1) != 0) v = -v;
         end
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return 16'h7FF8 + 16'($urandom_range(0, 15));
         1: return 16'($urandom_range(0, 300));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(input int n, input bit no_gaps);
      req_type ray;
      for (int i = 0; i < n; i++) begin
         ray.dir_x   = rand_dir();
         ray.dir_y   = rand_dir();
         ray.dir_z   = rand_dir();
         ray.start_x = rand_coord();
         ray.start_y = rand_coord();
         ray.start_z = rand_coord();
         case ($urandom_range(0, 15))
            0:       ray.step_count = '0;
            1:       ray.step_count = 7'($urandom_range(64, 127));
            2:       ray.step_count = 7'($urandom_range(13, 63));
            default: ray.step_count = 7'($urandom_range(1, 12));
         endcase
         send_ray(ray, 1'b0, '0, no_gaps);
      end
      req_valid <= 1'b0;
   endtask

   // Wait for the block to go idle, then write the floor register.
   task automatic write_floor(input logic [7:0] value);
      while (cells_due.size() != 0) @(posedge clock);
      // let the block settle back to idle before the write
      repeat (SETTLE) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      floor_model = value;
      floors_written++;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         cells_checked++;
         if (cells_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected cell %h", rsp_data));
         end else begin
            want = cells_due.pop_front();
            check_field("cell_x", rsp_data.cell_x, want.cell_x);
            check_field("cell_y", rsp_data.cell_y, want.cell_y);
            check_field("cell_z", rsp_data.cell_z, want.cell_z);
            check_field("end_x", rsp_data.end_x, want.end_x);
            check_field("end_y", rsp_data.end_y, want.end_y);
            check_field("end_z", rsp_data.end_z, want.end_z);
            check_field("last", {15'b0, rsp_data.last}, {15'b0, want.last});
         end
      end
   end

   initial begin : rsp_pacing
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (stall_request) begin
            // long hold-off so the block backs up into its input
            stall_request = 0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;

      // floor_y is at its reset value of 6 for the whole table
      directed_rays.push_back('{mk_ray(0, 0, 0, 0, 0, 0, 1), 1,
                                mk_cell(0, 0, 0, 0, 0, 0)});
      directed_rays.push_back('{mk_ray(1, 0, 0, 32767, 100, 0, 1), 1,
                                mk_cell(32767, 100, 0, -32768, 100, 0)});
      directed_rays.push_back('{mk_ray(-32768, 0, 0, -32768, 50, 5, 1), 1,
                                mk_cell(-32768, 50, 5, 32767, 50, 5)});
      directed_rays.push_back('{mk_ray(0, 32767, 0, 0, 10, 0, 1), 1,
                                mk_cell(0, 10, 0, 0, 11, 0)});
      directed_rays.push_back('{mk_ray(0, -1, 0, 0, 6, 0, 1), 1,
                                mk_cell(0, 6, 0, 0, 6, 0)});
      directed_rays.push_back('{mk_ray(0, 0, 32767, 1, 2, 3, 1), 1,
                                mk_cell(1, 2, 3, 1, 2, 4)});
      directed_rays.push_back('{mk_ray(0, 0, -32768, 1, 2, -32768, 1), 1,
                                mk_cell(1, 2, -32768, 1, 2, 32767)});
      directed_rays.push_back('{mk_ray(0, 1, 0, 0, 32767, 0, 1), 1,
                                mk_cell(0, 32767, 0, 0, 6, 0)});
      directed_rays.push_back('{mk_ray(100, -200, 300, 7, 8, 9, 0), 1, '0});
      directed_rays.push_back('{mk_ray(0, 0, 0, -5, -5, -5, 0), 1, '0});
      directed_rays.push_back('{mk_ray(-32768, -32768, -32768, 0, 0, 0, 1), 1,
                                mk_cell(0, 0, 0, 0, 0, -1)});
      directed_rays.push_back('{mk_ray(1234, -4321, 777, 10, 20, 30, 127), 0, '0});
      directed_rays.push_back('{mk_ray(-9000, 3000, 15000, -1, 7, 1, 64), 0, '0});
      directed_rays.push_back('{mk_ray(20000, 20000, -100, 0, 200, 0, 65), 0, '0});
      directed_rays.push_back('{mk_ray(0, 0, 0, -1, -1, -1, 5), 0, '0});
      directed_rays.push_back('{mk_ray(16384, 16384, 16384, 0, 50, 0, 9), 0, '0});
      directed_rays.push_back('{mk_ray(-1, -1, -1, 3, 20, 3, 8), 0, '0});
      directed_rays.push_back('{mk_ray(32767, -32768, 1, -32768, -32768, 32767, 12),
                                0, '0});
      directed_rays.push_back('{mk_ray(1, 1, 0, 0, 0, 0, 10), 0, '0});
      directed_rays.push_back('{mk_ray(-32768, -32768, -32768, 5, 300, 5, 20), 0, '0});
      directed_rays.push_back('{mk_ray(0, 5000, -3000, 4, 4, 4, 16), 0, '0});
      directed_rays.push_back('{mk_ray(12345, -23456, 345, 100, 200, 300, 8), 0, '0});
      directed_rays.push_back('{mk_ray(32767, 32767, 32767, 32767, 32767, 32767, 3),
                                0, '0});
      directed_rays.push_back('{mk_ray(2, 0, 0, 0, 0, 0, 6), 0, '0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rays[i])
         send_ray(directed_rays[i].ray, directed_rays[i].typed, directed_rays[i].want,
                  1'b0);
      req_valid <= 1'b0;

      write_floor(8'd0);
      stall_request = 1;
      run_phase(24, 1'b0);
      write_floor(8'd255);
      run_phase(24, 1'b0);
      write_floor(8'($urandom_range(1, 254)));
      run_phase(24, 1'b0);
      steady = 1;
      write_floor(8'($urandom));
      run_phase(24, 1'b1);

      while (cells_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d rays and %0d cells over %0d floor_y writes", rays_sent,
               cells_checked, floors_written);
      $display("rays spanned zero axes, ties, wraps, clamps and 0 to 127 steps");
      if (mismatch_count == 0) begin
         $display("voxel_ray_stepper_top: match");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("voxel_ray_stepper_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/vrs_pkg.sv
sv/vrs_div.sv
sv/voxel_ray_stepper_top.sv
dv/voxel_ray_stepper_top_test.sv
